// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held.
`define DCRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dcrp assertion failed");

// Concurrent assertion that also holds across reset.
`define DCRP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dcrp assertion failed");

`endif

// ===== hdl/dcrp_pkg.sv =====
// Shared types and constants of the disc checksum record parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcrp_pkg;

  // Field and port widths
  localparam int TRACK_W    = 7;
  localparam int OFFSET_W   = 10;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;

  // Record framing
  localparam int HEADER_LEN = 13;
  localparam logic [OFFSET_W-1:0] OFF_COUNT   = 10'd0;
  localparam logic [OFFSET_W-1:0] OFF_ID_ONE  = 10'd4;
  localparam logic [OFFSET_W-1:0] OFF_ID_TWO  = 10'd8;
  localparam logic [OFFSET_W-1:0] OFF_LOOKUP  = 10'd12;
  localparam logic [PHASE_W-1:0]  PH_CONF     = 4'd0;
  localparam logic [PHASE_W-1:0]  PH_CKSUM    = 4'd4;
  localparam logic [PHASE_W-1:0]  PH_ALT      = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKUP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

  // Result kinds and status codes
  localparam logic       KIND_ENTRY  = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  typedef enum logic [1:0] {
    S_READY,
    S_ENTRY,
    S_STATUS
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic sel_status;
  } dp_cmd_t;

  // Datapath to controller, about the byte on the input
  typedef struct packed {
    logic hit;
    logic fin;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dcrp_lenchk.sv =====
// Record size and body length check: remainder of the length by the record
// size, one length bit per cycle. Depends on dcrp_pkg.
`default_nettype none

module dcrp_lenchk import dcrp_pkg::*; #(
  parameter int MAX_TRACKS  = 99,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [TRACK_W-1:0]     tracks,
  input  wire logic [LENGTH_BITS-1:0] body_len,
  output logic      [OFFSET_W-1:0]    rec_size,
  output logic                        busy,
  output logic                        len_bad
);

  localparam int CNT_W = $clog2(LENGTH_BITS);

  logic [TRACK_W-1:0]  t_cl;
  logic                range_bad;
  logic [OFFSET_W:0]   trial;
  logic [OFFSET_W-1:0] rem_step;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OFFSET_W-1:0] rem_r, rem_nxt;
  logic                busy_r, busy_nxt;
  logic                bad_r, bad_nxt;

  // Clamped track count and record size 13 + 9 * tracks
  always_comb begin
    range_bad = (tracks == '0) || (tracks > TRACK_W'(MAX_TRACKS));
    if (tracks == '0) begin
      t_cl = TRACK_W'(1);
    end else if (tracks > TRACK_W'(MAX_TRACKS)) begin
      t_cl = TRACK_W'(MAX_TRACKS);
    end else begin
      t_cl = tracks;
    end
    rec_size = OFFSET_W'(HEADER_LEN) + ({3'b000, t_cl} << 3) + {3'b000, t_cl};
  end

  // One restoring step: shift in the next length bit, subtract if it fits
  always_comb begin
    trial = {rem_r, body_len[cnt_r]};
    if (trial >= {1'b0, rec_size}) begin
      rem_step = OFFSET_W'(trial - {1'b0, rec_size});
    end else begin
      rem_step = trial[OFFSET_W-1:0];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    bad_nxt  = bad_r;
    if (start) begin
      cnt_nxt  = CNT_W'(LENGTH_BITS - 1);
      rem_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        bad_nxt  = (rem_step != '0) || range_bad;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  // Reset starts a check against the reset register values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT_W'(LENGTH_BITS - 1);
      rem_r  <= '0;
      busy_r <= 1'b1;
      bad_r  <= 1'b1;
    end else begin
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      busy_r <= busy_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign busy    = busy_r;
  assign len_bad = bad_r;

endmodule

`default_nettype wire

// ===== hdl/dcrp_datapath.sv =====
// Datapath: configuration registers, record framing counters, header match,
// track field capture and the two result slots. Depends on dcrp_pkg.
`default_nettype none

module dcrp_datapath import dcrp_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  input  wire logic                   in_tlast,
  input  wire logic [OFFSET_W-1:0]    rec_size,
  input  wire logic                   len_bad,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  output logic      [TRACK_W-1:0]     tracks,
  output logic      [LENGTH_BITS-1:0] body_len,
  output logic      [OUT_DATA_W-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  // Configuration
  logic [TRACK_W-1:0]     tracks_r;
  logic [31:0]            id_one_r, id_two_r, lookup_r;
  logic [LENGTH_BITS-1:0] len_r;

  // Framing state
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic [PHASE_W-1:0]  ph_r, ph_nxt;
  logic [TRACK_W-1:0]  trk_r, trk_nxt;
  logic                hok_r, hok_nxt;
  logic                any_r, any_nxt;
  logic [31:0]         ws_r, ws_nxt;
  logic [31:0]         held_r, held_nxt;
  logic [7:0]          conf_r, conf_nxt;

  // Result slots
  logic [TRACK_W-1:0]  e_trk_r, e_trk_nxt;
  logic [7:0]          e_conf_r, e_conf_nxt;
  logic [31:0]         e_ck_r, e_ck_nxt;
  logic [31:0]         e_alt_r, e_alt_nxt;
  logic                e_end_r, e_end_nxt;
  logic [1:0]          st_r, st_nxt;

  logic [31:0] ws_new;
  logic        is_hdr;
  logic        closing;
  logic        hok_v;
  logic        any_v;

  assign ws_new  = {in_tdata, ws_r[31:8]};
  assign is_hdr  = off_r < OFFSET_W'(HEADER_LEN);
  assign closing = ({1'b0, off_r} + 11'd1) >= {1'b0, rec_size};

  assign stat.hit = !is_hdr && (ph_r == PH_ALT) && hok_r && !len_bad;
  assign stat.fin = in_tlast;

  assign tracks   = tracks_r;
  assign body_len = len_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracks_r <= TRACK_W'(1);
      id_one_r <= '0;
      id_two_r <= '0;
      lookup_r <= '0;
      len_r    <= LENGTH_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TRACKS: tracks_r <= cfg_wdata[TRACK_W-1:0];
        REG_ID_ONE: id_one_r <= cfg_wdata;
        REG_ID_TWO: id_two_r <= cfg_wdata;
        REG_LOOKUP: lookup_r <= cfg_wdata;
        REG_LENGTH: len_r    <= cfg_wdata[LENGTH_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Per-byte update of framing, header match and captured fields
  always_comb begin
    off_nxt    = off_r;
    ph_nxt     = ph_r;
    trk_nxt    = trk_r;
    hok_nxt    = hok_r;
    any_nxt    = any_r;
    ws_nxt     = ws_r;
    held_nxt   = held_r;
    conf_nxt   = conf_r;
    e_trk_nxt  = e_trk_r;
    e_conf_nxt = e_conf_r;
    e_ck_nxt   = e_ck_r;
    e_alt_nxt  = e_alt_r;
    e_end_nxt  = e_end_r;
    st_nxt     = st_r;
    hok_v      = hok_r;
    any_v      = any_r;
    if (cmd.load) begin
      ws_nxt = ws_new;
      if (off_r == OFF_COUNT) begin
        hok_v = (in_tdata == {1'b0, tracks_r});
      end else if (is_hdr) begin
        if ((off_r == OFF_ID_ONE) && (ws_new != id_one_r)) hok_v = 1'b0;
        if ((off_r == OFF_ID_TWO) && (ws_new != id_two_r)) hok_v = 1'b0;
        if (off_r == OFF_LOOKUP) begin
          if (ws_new != lookup_r) hok_v = 1'b0;
          if (hok_v) any_v = 1'b1;
          ph_nxt  = '0;
          trk_nxt = '0;
        end
      end else begin
        if (ph_r == PH_CONF)  conf_nxt = in_tdata;
        if (ph_r == PH_CKSUM) held_nxt = ws_new;
        if (ph_r == PH_ALT) begin
          ph_nxt  = '0;
          trk_nxt = trk_r + TRACK_W'(1);
        end else begin
          ph_nxt = ph_r + PHASE_W'(1);
        end
      end
      hok_nxt = hok_v;
      any_nxt = any_v;

      // Record end
      if (closing) begin
        off_nxt = '0;
        hok_nxt = 1'b1;
      end else begin
        off_nxt = off_r + OFFSET_W'(1);
      end

      // Entry slot
      if (stat.hit) begin
        e_trk_nxt  = trk_r;
        e_conf_nxt = conf_r;
        e_ck_nxt   = held_r;
        e_alt_nxt  = ws_new;
        e_end_nxt  = !in_tlast;
      end

      // Status slot; the final byte also restarts the body
      if (in_tlast) begin
        if (len_bad || !closing) begin
          st_nxt = ST_ERROR;
        end else if (any_v) begin
          st_nxt = ST_FOUND;
        end else begin
          st_nxt = ST_MISMATCH;
        end
        off_nxt = '0;
        hok_nxt = 1'b1;
        any_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      ph_r   <= '0;
      trk_r  <= '0;
      hok_r  <= 1'b1;
      any_r  <= 1'b0;
      ws_r   <= '0;
      held_r <= '0;
      conf_r <= '0;
    end else begin
      off_r  <= off_nxt;
      ph_r   <= ph_nxt;
      trk_r  <= trk_nxt;
      hok_r  <= hok_nxt;
      any_r  <= any_nxt;
      ws_r   <= ws_nxt;
      held_r <= held_nxt;
      conf_r <= conf_nxt;
    end
  end

  // Result slots carry payload only
  always_ff @(posedge clk) begin
    e_trk_r  <= e_trk_nxt;
    e_conf_r <= e_conf_nxt;
    e_ck_r   <= e_ck_nxt;
    e_alt_r  <= e_alt_nxt;
    e_end_r  <= e_end_nxt;
    st_r     <= st_nxt;
  end

  // Output word select
  always_comb begin
    if (cmd.sel_status) begin
      out_tdata = {7'd0, st_r, 79'd0};
      out_tuser = KIND_STATUS;
      out_tlast = 1'b1;
    end else begin
      out_tdata = {7'd0, ST_FOUND, e_alt_r, e_ck_r, e_conf_r, e_trk_r};
      out_tuser = KIND_ENTRY;
      out_tlast = e_end_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dcrp_ctrl.sv =====
// Controller: input acceptance and sequencing of the entry and status words.
// Depends on dcrp_pkg.
`default_nettype none

module dcrp_ctrl import dcrp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire logic     cfg_we,
  input  wire logic     len_busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic        accept;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READY;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    // A new byte may enter when no word is pending or the last pending word leaves this cycle
    slot_free = (state_r == S_READY) ||
                (out_tready && ((state_r == S_STATUS) ||
                                ((state_r == S_ENTRY) && !pend_r)));
    in_tready      = slot_free && !len_busy && !cfg_we;
    accept         = in_tvalid && in_tready;
    out_tvalid     = (state_r != S_READY);
    cmd.load       = accept;
    cmd.sel_status = (state_r == S_STATUS);

    state_nxt = state_r;
    pend_nxt  = pend_r;
    case (state_r)
      S_READY: begin
        state_nxt = S_READY;
      end
      S_ENTRY: begin
        if (out_tready) begin
          state_nxt = pend_r ? S_STATUS : S_READY;
          pend_nxt  = 1'b0;
        end
      end
      S_STATUS: begin
        if (out_tready) state_nxt = S_READY;
      end
      default: begin
        state_nxt = S_READY;
        pend_nxt  = 1'b0;
      end
    endcase

    // Results of the accepted byte
    if (accept) begin
      if (stat.hit) begin
        state_nxt = S_ENTRY;
        pend_nxt  = stat.fin;
      end else if (stat.fin) begin
        state_nxt = S_STATUS;
        pend_nxt  = 1'b0;
      end else begin
        state_nxt = S_READY;
        pend_nxt  = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/disc_checksum_record_parser.sv =====
// Top level of the disc checksum record parser.
// Depends on dcrp_pkg, dcrp_lenchk, dcrp_datapath and dcrp_ctrl.
//
// Usage:
//   The input stream carries the response body, one byte per word; in_tlast
//   marks the last byte. The output stream gives track entry words
//   (out_tuser 0) for matching records and one status word (out_tuser 1) on
//   the last byte: found, mismatch or length error. out_tlast marks the last
//   word caused by a byte.
//   Registers are written through cfg_we / cfg_idx / cfg_wdata. After reset
//   and after every register write the length check runs, one length bit per
//   cycle, with in_tready low.
//   Throughput: one byte per cycle while no word is pending. A word appears
//   in the cycle after the byte that causes it. A byte is taken in the cycle
//   its last pending word leaves, so a stall on out_tready holds the input
//   back; a byte with both an entry and the status keeps the input for two
//   words. Reset clears the record framing and the pending words.
`default_nettype none

module disc_checksum_record_parser import dcrp_pkg::*; #(
  parameter int MAX_TRACKS  = 99,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // body_byte[7:0]
  input  wire logic                  in_tlast,   // final_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // track_index[6:0], confidence[14:7], track_checksum[46:15],
  // alt_checksum[78:47], parse_status[80:79], zero fill[87:81]
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic                       out_tuser,  // result_kind
  output logic                       out_tlast   // run_end
);

  logic [TRACK_W-1:0]     tracks;
  logic [LENGTH_BITS-1:0] body_len;
  logic [OFFSET_W-1:0]    rec_size;
  logic                   len_busy;
  logic                   len_bad;
  dp_cmd_t                cmd;
  dp_stat_t               stat;

  dcrp_lenchk #(
    .MAX_TRACKS  (MAX_TRACKS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_lenchk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_we),
    .tracks   (tracks),
    .body_len (body_len),
    .rec_size (rec_size),
    .busy     (len_busy),
    .len_bad  (len_bad)
  );

  dcrp_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .rec_size  (rec_size),
    .len_bad   (len_bad),
    .cmd       (cmd),
    .stat      (stat),
    .tracks    (tracks),
    .body_len  (body_len),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  dcrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .len_busy   (len_busy),
    .stat       (stat),
    .cmd        (cmd)
  );

endmodule

`default_nettype wire

// ===== hdl/dcrp_checker.sv =====
// Port-level checks of the record parser, bound to the top level.
// Depends on dcrp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcrp_checker import dcrp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  // Stalled word holds
  `DCRP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // Status word closes the run, has no entry fields and a legal code
  `DCRP_ASSERT(a_status_word, clk, rst_n, out_tvalid && out_tuser |-> out_tlast && (out_tdata[78:0] == 79'd0) && (out_tdata[80:79] != 2'd3))
  // Entry word carries a zero status field
  `DCRP_ASSERT(a_entry_word, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[80:79] == ST_FOUND)
  // Length check runs out of reset, so no byte is taken right after it
  `DCRP_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |=> !in_tready)

endmodule

bind disc_checksum_record_parser dcrp_checker u_dcrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== test/tb_disc_checksum_record_parser.sv =====
// Testbench for the disc checksum record parser: streams response bodies byte by
// byte and checks every output word against a predictor of the record parsing.
// Depends on dcrp_pkg and disc_checksum_record_parser.

module tb_disc_checksum_record_parser import dcrp_pkg::*; ();

  localparam int MAX_TRACKS  = 99;
  localparam int LENGTH_BITS = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_GOAL   = 1700;
  localparam int SETTLE      = 4;

  typedef struct {
    logic [IN_DATA_W-1:0] data;
    logic                 last;
  } body_byte_t;

  typedef struct {
    logic               kind;
    logic [TRACK_W-1:0] track;
    logic [7:0]         conf;
    logic [31:0]        cksum;
    logic [31:0]        alt;
    logic [1:0]         status;
    logic               run_end;
  } parse_word_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_TRACKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;  // body_byte[7:0]
  logic                  in_tlast  = 1'b0;  // final_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // track_index[6:0], confidence[14:7], track_checksum[46:15],
  // alt_checksum[78:47], parse_status[80:79], zero fill[87:81]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;  // result_kind
  logic                  out_tlast;  // run_end

  // register copies, reset values
  logic [6:0]             tracks_cfg = 7'd1;
  logic [31:0]            id_one_cfg = '0;
  logic [31:0]            id_two_cfg = '0;
  logic [31:0]            lookup_cfg = '0;
  logic [LENGTH_BITS-1:0] length_cfg = 1;

  // parser state
  logic [OFFSET_W-1:0] rec_off    = '0;
  logic                header_hit = 1'b1;
  logic                any_hit    = 1'b0;
  logic [31:0]         shift_word = '0;
  logic [31:0]         held_cksum = '0;
  logic [7:0]          held_conf  = '0;

  body_byte_t  body_bytes[$];
  parse_word_t words_due[$];
  logic [7:0]  staged[$];

  int   error_count    = 0;
  int   bytes_sent     = 0;
  int   bytes_taken    = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   phase_no       = 0;
  logic hold_off       = 1'b0;

  disc_checksum_record_parser #(
    .MAX_TRACKS (MAX_TRACKS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // track count used for framing, clamped to the legal range
  function automatic int unsigned framed_tracks();
    if (tracks_cfg < 1) return 1;
    if (tracks_cfg > MAX_TRACKS) return MAX_TRACKS;
    return tracks_cfg;
  endfunction

  function automatic int unsigned record_bytes();
    return HEADER_LEN + 9 * framed_tracks();
  endfunction

  // advance the record framing by one body byte, queue the words it causes
  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    int unsigned        size;
    int unsigned        off;
    int unsigned        pos;
    logic               emit;
    logic               len_err;
    logic [TRACK_W-1:0] track;
    logic [1:0]         st;
    parse_word_t        w;
    size    = record_bytes();
    off     = rec_off;
    emit    = 1'b0;
    track   = '0;
    len_err = (tracks_cfg < 1) || (tracks_cfg > MAX_TRACKS) || (length_cfg % size != 0);
    shift_word = {b, shift_word[31:8]};

    if (off == OFF_COUNT) begin
      header_hit = (b == {1'b0, tracks_cfg});
    end else if (off < HEADER_LEN) begin
      if (off == OFF_ID_ONE && shift_word != id_one_cfg) header_hit = 1'b0;
      if (off == OFF_ID_TWO && shift_word != id_two_cfg) header_hit = 1'b0;
      if (off == OFF_LOOKUP) begin
        if (shift_word != lookup_cfg) header_hit = 1'b0;
        if (header_hit) any_hit = 1'b1;
      end
    end else begin
      pos   = off - HEADER_LEN;
      track = TRACK_W'(pos / 9);
      case (pos % 9)
        PH_CONF:  held_conf = b;
        PH_CKSUM: held_cksum = shift_word;
        PH_ALT:   emit = header_hit && !len_err;
        default: ;
      endcase
    end

    if (emit) begin
      w = '{kind: KIND_ENTRY, track: track, conf: held_conf, cksum: held_cksum,
            alt: shift_word, status: '0, run_end: !fin};
      words_due.push_back(w);
    end

    // an offset at or past the record end closes the record
    if (off + 1 >= size) begin
      rec_off    = '0;
      header_hit = 1'b1;
    end else begin
      rec_off = OFFSET_W'(off + 1);
    end

    if (fin) begin
      if (len_err || rec_off != 0) st = ST_ERROR;
      else if (any_hit)            st = ST_FOUND;
      else                         st = ST_MISMATCH;
      w = '{kind: KIND_STATUS, track: '0, conf: '0, cksum: '0, alt: '0,
            status: st, run_end: 1'b1};
      words_due.push_back(w);
      rec_off    = '0;
      header_hit = 1'b1;
      any_hit    = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_in
    body_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      // hold the word until taken, then offer the next one or idle
      if (!in_tvalid || in_tready) begin
        if (body_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = body_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_out
    parse_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (words_due.size() == 0) begin
        report_error($sformatf("unexpected word %h kind %b", out_tdata, out_tuser));
      end else begin
        w = words_due.pop_front();
        check_field("result_kind", out_tuser, w.kind);
        check_field("track_index", out_tdata[6:0], w.track);
        check_field("confidence", out_tdata[14:7], w.conf);
        check_field("track_checksum", out_tdata[46:15], w.cksum);
        check_field("alt_checksum", out_tdata[78:47], w.alt);
        check_field("parse_status", out_tdata[80:79], w.status);
        check_field("zero fill", out_tdata[87:81], '0);
        check_field("run_end", out_tlast, w.run_end);
      end
    end
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off early in the first random phase
  initial begin : long_hold
    wait (phase_no == 1);
    repeat (80) @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TRACKS: tracks_cfg = val[6:0];
      REG_ID_ONE: id_one_cfg = val;
      REG_ID_TWO: id_two_cfg = val;
      REG_LOOKUP: lookup_cfg = val;
      REG_LENGTH: length_cfg = val[LENGTH_BITS-1:0];
      default: ;
    endcase
  endtask

  // every byte taken and every word delivered, then a short settle
  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_taken != bytes_sent || words_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one record for the current registers; a miss flips one header bit
  task automatic stage_record(input logic hit);
    logic [7:0] head[HEADER_LEN];
    int         flip;
    int         t;
    int         k;
    head[0] = {1'b0, tracks_cfg};
    for (k = 0; k < 4; k++) begin
      head[1 + k] = id_one_cfg[8*k +: 8];
      head[5 + k] = id_two_cfg[8*k +: 8];
      head[9 + k] = lookup_cfg[8*k +: 8];
    end
    if (!hit) begin
      flip = $urandom_range(8 * HEADER_LEN - 1);
      head[flip / 8][flip % 8] = ~head[flip / 8][flip % 8];
    end
    for (k = 0; k < HEADER_LEN; k++) staged.push_back(head[k]);
    for (t = 0; t < framed_tracks(); t++)
      for (k = 0; k < 9; k++) staged.push_back(8'($urandom));
  endtask

  // hand staged bytes to the driver; closes marks the last one final
  task automatic launch(input int count, input logic closes);
    int k;
    for (k = 0; k < count; k++)
      body_bytes.push_back('{data: staged.pop_front(), last: closes && (k == count - 1)});
    bytes_sent += count;
  endtask

  task automatic retune();
    write_reg(REG_TRACKS, ($urandom_range(99) < 80) ? $urandom_range(4, 1)
                                                     : $urandom_range(12, 5));
    write_reg(REG_ID_ONE, pick_id());
    write_reg(REG_ID_TWO, pick_id());
    write_reg(REG_LOOKUP, pick_id());
  endtask

  task automatic random_body();
    int         roll;
    int         n_rec;
    int         k;
    int         split;
    logic [6:0] keep_tracks;
    wait_idle();
    if ($urandom_range(3) == 0) retune();
    roll  = $urandom_range(99);
    n_rec = $urandom_range(3, 1);
    if (roll < 72 || roll >= 82)
      for (k = 0; k < n_rec; k++) stage_record($urandom_range(99) < 60);

    if (roll < 60) begin
      // well formed; now and then the length is not a whole number of records
      write_reg(REG_LENGTH, n_rec * record_bytes() +
                ((($urandom_range(9) == 0)) ? $urandom_range(record_bytes() - 1, 1) : 0));
      launch(staged.size(), 1'b1);
    end else if (roll < 72) begin
      // final byte arrives early or late
      write_reg(REG_LENGTH, n_rec * record_bytes());
      if ($urandom_range(1)) repeat ($urandom_range(5, 1)) void'(staged.pop_back());
      else repeat ($urandom_range(5, 1)) staged.push_back(8'($urandom));
      launch(staged.size(), 1'b1);
    end else if (roll < 82) begin
      // noise, sometimes with a track count out of range
      keep_tracks = tracks_cfg;
      if ($urandom_range(1)) write_reg(REG_TRACKS, $urandom_range(1) ? 0 : 127);
      case ($urandom_range(4))
        0:       write_reg(REG_LENGTH, 1);
        1:       write_reg(REG_LENGTH, 24'hFF_FFFF);
        default: write_reg(REG_LENGTH, $urandom_range(24'hFF_FFFF, 1));
      endcase
      repeat ($urandom_range(40, 1)) staged.push_back(8'($urandom));
      launch(staged.size(), 1'b1);
      if (tracks_cfg != keep_tracks) begin
        wait_idle();
        write_reg(REG_TRACKS, keep_tracks);
      end
    end else if (roll < 92) begin
      // identifier rewritten partway through the body
      write_reg(REG_LENGTH, n_rec * record_bytes());
      split = $urandom_range(staged.size() - 1, 1);
      launch(split, 1'b0);
      wait_idle();
      case ($urandom_range(3))
        0:       write_reg(REG_ID_ONE, pick_id());
        1:       write_reg(REG_ID_TWO, pick_id());
        2:       write_reg(REG_LOOKUP, pick_id());
        default: write_reg(REG_ID_ONE, id_one_cfg);
      endcase
      launch(staged.size(), 1'b1);
    end else begin
      // two bodies back to back, no pause between them
      write_reg(REG_LENGTH, n_rec * record_bytes());
      launch(staged.size(), 1'b1);
      for (k = 0; k < n_rec; k++) stage_record($urandom_range(99) < 60);
      launch(staged.size(), 1'b1);
    end
  endtask

  initial begin : stimulus
    int k;
    int phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // lone final byte, body length of one is not a whole record
    write_reg(REG_LENGTH, 1);
    staged.push_back(8'h00);
    launch(1, 1'b1);
    wait_idle();

    // matching single-track record with extreme field values; the final
    // byte gives both the entry and the status
    write_reg(REG_TRACKS, 1);
    write_reg(REG_ID_ONE, 32'hFFFF_FFFF);
    write_reg(REG_ID_TWO, 32'h0000_0000);
    write_reg(REG_LOOKUP, 32'h5A3C_96E1);
    write_reg(REG_LENGTH, record_bytes());
    stage_record(1'b1);
    for (k = 13; k < 18; k++) staged[k] = 8'hFF;
    for (k = 18; k < 22; k++) staged[k] = 8'h00;
    launch(staged.size(), 1'b1);

    // final byte two bytes into a record
    staged.push_back(8'h01);
    staged.push_back(8'hFF);
    launch(2, 1'b1);

    // random phases with different idling on each side
    for (k = 1; k <= 4; k++) begin
      wait_idle();
      phase_no <= k;
      case (k)
        1:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        2:       begin send_idle_pct <= 58; recv_stall_pct <= 0;  end
        3:       begin send_idle_pct <= 0;  recv_stall_pct <= 58; end
        default: begin send_idle_pct <= 15; recv_stall_pct <= 15; end
      endcase
      if (k == 1) begin
        // one record at the largest track count
        write_reg(REG_TRACKS, MAX_TRACKS);
        write_reg(REG_LENGTH, record_bytes());
        stage_record(1'b1);
        launch(staged.size(), 1'b1);
        wait_idle();
        write_reg(REG_TRACKS, 3);
      end
      // spread what is left of the byte budget over the remaining phases
      phase_end = bytes_sent + (BYTE_GOAL - bytes_sent) / (5 - k);
      while (bytes_sent < phase_end) random_body();
    end

    // drain with a bound, then let the block settle
    for (k = 0; k < 5000 && (bytes_taken != bytes_sent || words_due.size() != 0); k++)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (bytes_taken != bytes_sent)
      report_error($sformatf("%0d bytes never taken", bytes_sent - bytes_taken));
    if (words_due.size() != 0)
      report_error($sformatf("%0d words never arrived", words_due.size()));
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dcrp_pkg.sv
hdl/dcrp_lenchk.sv
hdl/dcrp_datapath.sv
hdl/dcrp_ctrl.sv
hdl/disc_checksum_record_parser.sv
hdl/dcrp_checker.sv
test/tb_disc_checksum_record_parser.sv
